// ===== rtl/stl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants of the source text lexer
// Holds character codes, token kinds, state encodings and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package stl_pkg;

	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_LU    = 8'h75;
	localparam logic [7:0] CH_UU    = 8'h55;
	localparam logic [7:0] CH_LL    = 8'h6C;
	localparam logic [7:0] CH_UL    = 8'h4C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;

	localparam logic [2:0] KIND_IDENT  = 3'd0;
	localparam logic [2:0] KIND_STRING = 3'd1;
	localparam logic [2:0] KIND_SYMBOL = 3'd2;
	localparam logic [2:0] KIND_INT    = 3'd3;
	localparam logic [2:0] KIND_UINT   = 3'd4;
	localparam logic [2:0] KIND_LONG   = 3'd5;
	localparam logic [2:0] KIND_ULONG  = 3'd6;

	localparam logic REG_KEEP_SPACES = 1'b0;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_WORD,
		MODE_NUM,
		MODE_NUMU,
		MODE_STR
	} lex_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROC,
		ST_PUSH2,
		ST_RD,
		ST_OUT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_ONE,
		RES_TEXT,
		RES_PUSH2
	} proc_res_t;

	typedef struct packed {
		logic take;
		logic proc;
		logic push2;
		logic rd;
		logic adv;
	} ctrl_cmd_t;

	typedef struct packed {
		proc_res_t res;
		logic      text_more;
		logic      again;
	} dp_stat_t;

endpackage

// ===== rtl/stl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 63,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/stl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_ctrl: lexer controller
// Sequences request intake, one processing step, an optional second buffer
// write, buffered text readout and result delivery.
// ----------------------------------------------------------------------------
module stl_ctrl import stl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      char_valid,
	output logic      char_stall,
	output logic      token_valid,
	input  logic      token_stall,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	ctrl_state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n     = state_q;
		cmd         = '0;
		char_stall  = 1'b1;
		token_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				char_stall = 1'b0;
				if (char_valid) begin
					cmd.take = 1'b1;
					state_n  = ST_PROC;
				end
			end
			ST_PROC: begin
				cmd.proc = 1'b1;
				unique case (stat.res)
					RES_NONE:  state_n = ST_IDLE;
					RES_ONE:   state_n = ST_OUT;
					RES_TEXT:  state_n = ST_RD;
					RES_PUSH2: state_n = ST_PUSH2;
					default:   state_n = ST_IDLE;
				endcase
			end
			ST_PUSH2: begin
				cmd.push2 = 1'b1;
				state_n   = ST_IDLE;
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_n = ST_OUT;
			end
			ST_OUT: begin
				token_valid = 1'b1;
				if (!token_stall) begin
					priority if (stat.text_more) begin
						cmd.adv = 1'b1;
						state_n = ST_RD;
					end else if (stat.again) begin
						state_n = ST_PROC;
					end else begin
						state_n = ST_IDLE;
					end
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/stl_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_dp: lexer datapath
// Token state, number accumulation, text buffer and result registers.
// ----------------------------------------------------------------------------
module stl_dp import stl_pkg::*; #(
	parameter int MAX_TEXT  = 63,
	parameter int LONG_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctrl_cmd_t   cmd,
	output dp_stat_t    stat,
	input  logic        keep_spaces,
	input  logic [7:0]  char_byte,
	input  logic        is_end,
	output logic [2:0]  token_kind,
	output logic        has_error,
	output logic [63:0] number_value,
	output logic [7:0]  text_byte,
	output logic        text_valid,
	output logic        token_end,
	output logic        run_last
);

	localparam int LW = $clog2(MAX_TEXT + 1);
	localparam int AW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
	localparam logic [LW-1:0] MAX_LEN = LW'(MAX_TEXT);
	localparam logic [63:0] LMAX  = (64'd1 << (LONG_BITS - 1)) - 64'd1;
	localparam logic [63:0] ULMAX = (LMAX << 1) | 64'd1;

	// Input byte and token state.
	logic [7:0]    c_q;
	logic          end_q;
	lex_mode_t     mode_q, mode_n;
	logic [63:0]   acc_q, acc_n;
	logic          ovf_q, ovf_n;
	logic [LW-1:0] len_q;
	logic          esc_q, esc_n;
	logic          err_q, err_n;

	// Emission state and result registers.
	logic [LW-1:0] emit_len_q;
	logic [LW-1:0] idx_q;
	logic          text_act_q;
	logic          again_q;
	logic          text_rl_q;
	logic [2:0]    kind_q;
	logic          oerr_q;
	logic [63:0]   oval_q;
	logic [7:0]    obyte_q;
	logic          otv_q;
	logic          olast_q;

	logic [7:0]    ram_rdata;

	// Step decision.
	proc_res_t     res;
	logic          again_n;
	logic          clear;
	logic          push_p;
	logic [7:0]    push_d;
	logic          one_num;
	logic [2:0]    one_kind;
	logic          skip, digit, alpha, wordch, will_sym;
	logic [67:0]   acc10;
	logic [63:0]   lim;
	logic          num_err;
	logic          push_en;
	logic [7:0]    push_data;
	logic          room;
	logic          tlast;

	assign skip = (c_q == CH_LF) || (c_q == CH_TAB) || (c_q == CH_CR)
		|| ((c_q == CH_SPACE) && !keep_spaces);
	assign digit  = (c_q >= 8'h30) && (c_q <= 8'h39);
	assign alpha  = ((c_q >= 8'h61) && (c_q <= 8'h7A)) || ((c_q >= 8'h41) && (c_q <= 8'h5A));
	assign wordch = alpha || digit || (c_q == CH_UNDER);
	// A rescanned byte makes a symbol of its own when it starts nothing else.
	assign will_sym = !skip && !wordch && (c_q != CH_QUOTE);

	assign acc10 = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + 68'(c_q[3:0]);

	always_comb begin
		res      = RES_NONE;
		again_n  = 1'b0;
		clear    = 1'b0;
		push_p   = 1'b0;
		push_d   = c_q;
		one_num  = 1'b0;
		one_kind = KIND_SYMBOL;
		mode_n   = mode_q;
		acc_n    = acc_q;
		ovf_n    = ovf_q;
		esc_n    = esc_q;
		err_n    = err_q;
		if (end_q) begin
			clear = 1'b1;
			unique case (mode_q)
				MODE_WORD: begin
					res      = RES_TEXT;
					one_kind = KIND_IDENT;
				end
				MODE_NUM, MODE_NUMU: begin
					res      = RES_ONE;
					one_num  = 1'b1;
					one_kind = KIND_INT;
				end
				default: res = RES_NONE;
			endcase
		end else begin
			unique case (mode_q)
				MODE_IDLE: begin
					if (!skip) begin
						priority if (digit) begin
							mode_n = MODE_NUM;
							acc_n  = 64'(c_q[3:0]);
						end else if (wordch) begin
							mode_n = MODE_WORD;
							push_p = 1'b1;
						end else if (c_q == CH_QUOTE) begin
							mode_n = MODE_STR;
						end else begin
							res = RES_ONE;
						end
					end
				end
				MODE_WORD: begin
					if (!skip && wordch) begin
						push_p = 1'b1;
					end else begin
						res      = RES_TEXT;
						one_kind = KIND_IDENT;
						clear    = 1'b1;
						again_n  = !skip;
					end
				end
				MODE_NUM: begin
					priority if (!skip && digit) begin
						if (acc10[67:64] != 4'd0) begin
							ovf_n = 1'b1;
						end else begin
							acc_n = acc10[63:0];
						end
					end else if (!skip && ((c_q == CH_LU) || (c_q == CH_UU))) begin
						mode_n = MODE_NUMU;
					end else if (!skip && ((c_q == CH_LL) || (c_q == CH_UL))) begin
						res      = RES_ONE;
						one_num  = 1'b1;
						one_kind = KIND_LONG;
						clear    = 1'b1;
					end else begin
						res      = RES_ONE;
						one_num  = 1'b1;
						one_kind = KIND_INT;
						clear    = 1'b1;
						again_n  = !skip;
					end
				end
				MODE_NUMU: begin
					res     = RES_ONE;
					one_num = 1'b1;
					clear   = 1'b1;
					if ((c_q == CH_LL) || (c_q == CH_UL)) begin
						one_kind = KIND_ULONG;
					end else begin
						one_kind = KIND_UINT;
						again_n  = 1'b1;
					end
				end
				default: begin
					one_kind = KIND_STRING;
					priority if (c_q == CH_QUOTE) begin
						if (!esc_q) begin
							res   = (len_q == '0) ? RES_ONE : RES_TEXT;
							clear = 1'b1;
						end else begin
							esc_n  = 1'b0;
							push_p = 1'b1;
						end
					end else if (c_q == CH_BSL) begin
						if (!esc_q) begin
							esc_n = 1'b1;
						end else begin
							esc_n  = 1'b0;
							push_p = 1'b1;
						end
					end else if (esc_q) begin
						if ((c_q == CH_T) || (c_q == CH_N) || (c_q == CH_R)
							|| (c_q == CH_B) || (c_q == CH_F)) begin
							// Known escapes keep the backslash and the letter.
							esc_n  = 1'b0;
							push_p = 1'b1;
							push_d = CH_BSL;
							res    = RES_PUSH2;
						end else begin
							err_n = 1'b1;
						end
					end else if (!err_q) begin
						push_p = 1'b1;
					end
				end
			endcase
		end
	end

	always_comb begin
		unique case (one_kind)
			KIND_INT:  lim = 64'h0000_0000_7FFF_FFFF;
			KIND_UINT: lim = 64'h0000_0000_FFFF_FFFF;
			KIND_LONG: lim = LMAX;
			default:   lim = ULMAX;
		endcase
	end
	assign num_err = ovf_q || (acc_q > lim);

	assign push_en   = (cmd.proc && push_p) || cmd.push2;
	assign push_data = cmd.push2 ? c_q : push_d;
	assign room      = len_q < MAX_LEN;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			c_q   <= char_byte;
			end_q <= is_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			acc_q      <= '0;
			ovf_q      <= 1'b0;
			len_q      <= '0;
			esc_q      <= 1'b0;
			err_q      <= 1'b0;
			text_act_q <= 1'b0;
			again_q    <= 1'b0;
			idx_q      <= '0;
		end else begin
			if (cmd.proc) begin
				again_q    <= again_n;
				text_act_q <= (res == RES_TEXT);
				idx_q      <= '0;
				if (clear) begin
					mode_q <= MODE_IDLE;
					acc_q  <= '0;
					ovf_q  <= 1'b0;
					len_q  <= '0;
					esc_q  <= 1'b0;
					err_q  <= 1'b0;
				end else begin
					mode_q <= mode_n;
					acc_q  <= acc_n;
					ovf_q  <= ovf_n;
					esc_q  <= esc_n;
					// A character that finds the buffer full marks the token.
					err_q  <= err_n || (push_en && !room);
				end
			end else if (cmd.push2 && !room) begin
				err_q <= 1'b1;
			end
			if (push_en && room) begin
				len_q <= len_q + LW'(1);
			end
			if (cmd.adv) begin
				idx_q <= idx_q + LW'(1);
			end
		end
	end

	// Result registers, loaded on every processing step.
	always_ff @(posedge clk) begin
		if (cmd.proc) begin
			emit_len_q <= len_q;
			kind_q     <= one_num ? one_kind : ((mode_q == MODE_IDLE) ? KIND_SYMBOL : one_kind);
			oerr_q     <= one_num ? num_err : ((mode_q == MODE_IDLE) ? 1'b0 : err_q);
			oval_q     <= (one_num && !num_err) ? acc_q : 64'd0;
			obyte_q    <= (!one_num && (mode_q == MODE_IDLE)) ? c_q : 8'd0;
			otv_q      <= !one_num && (mode_q == MODE_IDLE);
			olast_q    <= !(again_n && will_sym);
			text_rl_q  <= !(again_n && will_sym);
		end
	end

	stl_ram #(
		.WIDTH (8),
		.DEPTH (MAX_TEXT),
		.AW    (AW)
	) u_text_ram (
		.clk   (clk),
		.we    (push_en && room),
		.waddr (len_q[AW-1:0]),
		.wdata (push_data),
		.re    (cmd.rd),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign tlast          = (idx_q + LW'(1)) == emit_len_q;
	assign stat.res       = res;
	assign stat.text_more = text_act_q && !tlast;
	assign stat.again     = again_q;

	assign token_kind   = kind_q;
	assign has_error    = oerr_q;
	assign number_value = oval_q;
	assign text_byte    = text_act_q ? ram_rdata : obyte_q;
	assign text_valid   = text_act_q ? 1'b1 : otv_q;
	assign token_end    = text_act_q ? tlast : 1'b1;
	assign run_last     = text_act_q ? (tlast && text_rl_q) : olast_q;

endmodule

// ===== rtl/source_text_lexer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_lexer_unit: streaming source text lexer
// Splits a byte stream into identifiers, numbers, strings and symbols.
// ----------------------------------------------------------------------------
// Sequence: a request is taken in the idle state and processed in the next
// cycle; a single result is shown from the result registers, while buffered
// text is read from the text buffer before each character is shown. A new
// request is taken only once all results are delivered. A backslash escape
// that keeps two characters adds a second buffer write, and each buffered text
// character needs a text buffer read, then delivery; the buffer has one read port.
// Reset: arst_n clears the controller and token state at once; the text
// buffer is not cleared and needs no clearing pass.
module source_text_lexer_unit import stl_pkg::*; #(
	parameter int MAX_TEXT  = 63,
	parameter int LONG_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Source byte requests.
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_byte,
	input  logic        is_end,
	// Token result requests.
	output logic        token_valid,
	input  logic        token_stall,
	output logic [2:0]  token_kind,
	output logic        has_error,
	output logic [63:0] number_value,
	output logic [7:0]  text_byte,
	output logic        text_valid,
	output logic        token_end,
	output logic        run_last
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	logic      keep_q;

	// The only register is keep_spaces, decoded where paddr[2] is zero (byte addresses
	// zero to three). Writes with paddr[2] set are ignored and read back as zero.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_KEEP_SPACES) ? {31'd0, keep_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_KEEP_SPACES)) begin
			keep_q <= pwdata[0];
		end
	end

	// The controller decides when a request is taken and when a result
	// is shown; the datapath holds all token state and the text buffer.
	stl_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.stat        (stat),
		.cmd         (cmd)
	);

	stl_dp #(
		.MAX_TEXT  (MAX_TEXT),
		.LONG_BITS (LONG_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.keep_spaces  (keep_q),
		.char_byte    (char_byte),
		.is_end       (is_end),
		.token_kind   (token_kind),
		.has_error    (has_error),
		.number_value (number_value),
		.text_byte    (text_byte),
		.text_valid   (text_valid),
		.token_end    (token_end),
		.run_last     (run_last)
	);

`ifndef NO_ASSERTIONS
	// A new request is only taken while no result is waiting.
	a_no_take_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		!char_stall |-> !token_valid)
		else $error("request taken while a result is pending");

	// The last result of a request always closes a token.
	a_last_ends_token: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && run_last |-> token_end)
		else $error("run_last on a result that does not end a token");

	// Number results never carry text.
	a_num_no_text: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && (token_kind == KIND_INT || token_kind == KIND_UINT
		|| token_kind == KIND_LONG || token_kind == KIND_ULONG) |-> !text_valid)
		else $error("number result carries text");
`endif

endmodule

// ===== sim/tb_source_text_lexer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_source_text_lexer_unit: self-checking bench of the source text lexer
// Feeds byte requests and end marks, predicts every token result in the
// bench and compares each delivered result field by field, with random
// idling on both sides, a long receiver hold-off and keep_spaces phases.
// ----------------------------------------------------------------------------
module tb_source_text_lexer_unit;
	import stl_pkg::*;

	localparam int LIMIT      = 400000;
	localparam int HOLD_LEN   = 400;
	localparam int DRAIN_WAIT = 20;

	// One expected token result, as the block delivers it.
	typedef struct {
		logic [2:0]  kind;
		logic        err;
		logic [63:0] value;
		logic [7:0]  tbyte;
		logic        tvalid;
		logic        tend;
		logic        last;
	} token_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        char_valid = 1'b0;
	logic        char_stall;
	logic [7:0]  char_byte = '0;
	logic        is_end = 1'b0;
	logic        token_valid;
	logic        token_stall = 1'b0;
	logic [2:0]  token_kind;
	logic        has_error;
	logic [63:0] number_value;
	logic [7:0]  text_byte;
	logic        text_valid;
	logic        token_end;
	logic        run_last;

	source_text_lexer_unit dut (.*);

	always #1 clk = ~clk;

	// Shared bench state: expected tokens, error tally and activity counters.
	token_t      tokens_due[$];
	token_t      step_tokens[$];
	int          errors = 0;
	int          cycles = 0;
	int          bytes_sent = 0;
	int          tokens_seen = 0;
	bit          gaps_on = 1'b1;
	int          hold_req = 0;
	int          hold_seen = 0;
	int          hold_left = 0;

	// Mirror of the lexer state kept by the predictor.
	logic        keep_sp;
	lex_mode_t   mode;
	logic [63:0] acc;
	logic        num_ovf;
	logic [7:0]  text_buf [0:62];
	logic [6:0]  text_len;
	logic        esc;
	logic        tok_err;

	// The run is cut off if it ever takes far longer than the slowest correct run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_source_text_lexer_unit failed");
			$finish;
		end
	end

	// Predictor helpers; add_token and the flush functions queue tokens for the current request.
	function automatic void add_token(logic [2:0] k, logic e, logic [63:0] v,
			logic [7:0] b, logic tv, logic te);
		token_t t;
		t = '{k, e, v, b, tv, te, 1'b0};
		if (step_tokens.size() < 64)
			step_tokens = {step_tokens, t};
	endfunction

	function automatic void clear_token();
		mode = MODE_IDLE;
		acc = '0;
		num_ovf = 1'b0;
		text_len = '0;
		esc = 1'b0;
		tok_err = 1'b0;
	endfunction

	function automatic void store_char(logic [7:0] c);
		if (text_len < 63) begin
			text_buf[text_len] = c;
			text_len++;
		end else begin
			tok_err = 1'b1;
		end
	endfunction

	function automatic void flush_text(logic [2:0] k);
		if (text_len == 0)
			add_token(k, tok_err, '0, '0, 1'b0, 1'b1);
		for (int i = 0; i < text_len; i++)
			add_token(k, tok_err, '0, text_buf[i], 1'b1, i + 1 == text_len);
	endfunction

	function automatic void flush_number(logic [2:0] k);
		logic [63:0] lim;
		case (k)
			KIND_INT: lim = 64'h7FFF_FFFF;
			KIND_UINT: lim = 64'hFFFF_FFFF;
			KIND_LONG: lim = 64'h7FFF_FFFF_FFFF_FFFF;
			default: lim = '1;
		endcase
		if (num_ovf || acc > lim)
			add_token(k, 1'b1, '0, '0, 1'b0, 1'b1);
		else
			add_token(k, 1'b0, acc, '0, 1'b0, 1'b1);
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	// Works out the tokens caused by one accepted request and queues them.
	function automatic void predict_tokens(logic [7:0] c, logic e);
		bit skip, again;
		logic [63:0] d;
		step_tokens.delete();
		if (e) begin
			if (mode == MODE_WORD)
				flush_text(KIND_IDENT);
			else if (mode == MODE_NUM || mode == MODE_NUMU)
				flush_number(KIND_INT);
			clear_token();
		end else begin
			skip = c == CH_LF || c == CH_TAB || c == CH_CR || (c == CH_SPACE && !keep_sp);
			again = 1'b1;
			while (again) begin
				again = 1'b0;
				case (mode)
					MODE_IDLE: begin
						if (!skip) begin
							clear_token();
							if (is_digit(c)) begin
								mode = MODE_NUM;
								acc = 64'(c - "0");
							end else if (is_letter(c) || c == CH_UNDER) begin
								mode = MODE_WORD;
								store_char(c);
							end else if (c == CH_QUOTE) begin
								mode = MODE_STR;
							end else begin
								add_token(KIND_SYMBOL, 1'b0, '0, c, 1'b1, 1'b1);
							end
						end
					end
					MODE_WORD: begin
						if (!skip && (is_letter(c) || is_digit(c) || c == CH_UNDER)) begin
							store_char(c);
						end else begin
							flush_text(KIND_IDENT);
							clear_token();
							again = !skip;
						end
					end
					MODE_NUM: begin
						if (!skip && is_digit(c)) begin
							d = 64'(c - "0");
							if (acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10)
								num_ovf = 1'b1;
							else
								acc = acc * 10 + d;
						end else if (!skip && (c == CH_LU || c == CH_UU)) begin
							mode = MODE_NUMU;
						end else if (!skip && (c == CH_LL || c == CH_UL)) begin
							flush_number(KIND_LONG);
							clear_token();
						end else begin
							flush_number(KIND_INT);
							clear_token();
							again = !skip;
						end
					end
					MODE_NUMU: begin
						if (c == CH_LL || c == CH_UL) begin
							flush_number(KIND_ULONG);
							clear_token();
						end else begin
							flush_number(KIND_UINT);
							clear_token();
							again = 1'b1;
						end
					end
					default: begin
						if (c == CH_QUOTE) begin
							if (!esc) begin
								flush_text(KIND_STRING);
								clear_token();
							end else begin
								esc = 1'b0;
								store_char(CH_QUOTE);
							end
						end else if (c == CH_BSL) begin
							if (!esc) begin
								esc = 1'b1;
							end else begin
								esc = 1'b0;
								store_char(CH_BSL);
							end
						end else if (esc) begin
							if (c == CH_T || c == CH_N || c == CH_R || c == CH_B || c == CH_F) begin
								esc = 1'b0;
								store_char(CH_BSL);
								store_char(c);
							end else begin
								tok_err = 1'b1;
							end
						end else if (!tok_err) begin
							store_char(c);
						end
					end
				endcase
			end
		end
		if (step_tokens.size() > 0)
			step_tokens[$].last = 1'b1;
		foreach (step_tokens[i])
			tokens_due = {tokens_due, step_tokens[i]};
	endfunction

	// Sends one request, idling first at random, and predicts it on acceptance.
	// Valid stays high afterwards so back-to-back requests need no extra edge.
	task automatic send_char(input logic [7:0] c, input logic e);
		if (gaps_on && $urandom_range(99) < 23) begin
			char_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_byte <= c;
		is_end <= e;
		do @(posedge clk); while (char_stall);
		predict_tokens(c, e);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], 1'b0);
	endtask

	// Waits until every expected token is in and the block has settled,
	// then writes keep_spaces through the configuration port.
	task automatic write_keep_spaces(input logic v);
		@(posedge clk);
		char_valid <= 1'b0;
		wait (tokens_due.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {REG_KEEP_SPACES, 2'b00};
		pwdata <= {31'b0, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		keep_sp = v;
	endtask

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	// The checker compares each accepted result with the oldest expectation.
	always @(posedge clk) begin
		token_t t;
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_LEN;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
		token_stall <= hold_left > 1 || (gaps_on && $urandom_range(99) < 23);
		if (arst_n && token_valid && !token_stall) begin
			tokens_seen++;
			if (tokens_due.size() == 0) begin
				$error("unexpected token result: kind %0d text %02h", token_kind, text_byte);
				errors++;
			end else begin
				t = tokens_due.pop_front();
				if (token_kind !== t.kind) begin
					$error("token_kind: expected %0d, got %0d", t.kind, token_kind);
					errors++;
				end
				if (has_error !== t.err) begin
					$error("has_error: expected %0d, got %0d", t.err, has_error);
					errors++;
				end
				if (number_value !== t.value) begin
					$error("number_value: expected %0d, got %0d", t.value, number_value);
					errors++;
				end
				if (text_byte !== t.tbyte) begin
					$error("text_byte: expected %02h, got %02h", t.tbyte, text_byte);
					errors++;
				end
				if (text_valid !== t.tvalid) begin
					$error("text_valid: expected %0d, got %0d", t.tvalid, text_valid);
					errors++;
				end
				if (token_end !== t.tend) begin
					$error("token_end: expected %0d, got %0d", t.tend, token_end);
					errors++;
				end
				if (run_last !== t.last) begin
					$error("run_last: expected %0d, got %0d", t.last, run_last);
					errors++;
				end
			end
		end
	end

	// Separators, symbols at the byte extremes, and identifiers.
	task automatic test_words_symbols();
		send_text(" \t\n\r");
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_text("_a9 Zz+");
		send_char(8'h00, 1'b1);
	endtask

	// Every number suffix form and the range limits of int, uint and the 64-bit accumulator.
	task automatic test_numbers();
		send_text("2147483648 4294967295u 7l 9uL ");
		send_text("18446744073709551616 3u");
		send_char(8'hFF, 1'b1);
	endtask

	// Escapes, a bad escape, the empty string and an unterminated string.
	task automatic test_strings();
		send_text("\"a\\\"\\\\\\tq\\qz\\n\"\"\"\"ab");
		send_char(8'h20, 1'b1);
	endtask

	// One random token or piece of noise, mostly well formed.
	task automatic send_random_token();
		int pick, n;
		pick = $urandom_range(99);
		if (pick < 25) begin
			n = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(3))
					0: send_char(CH_UNDER, 1'b0);
					1: send_char(8'("0" + $urandom_range(9)), 1'b0);
					2: send_char(8'("A" + $urandom_range(25)), 1'b0);
					default: send_char(8'("a" + $urandom_range(25)), 1'b0);
				endcase
			end
		end else if (pick < 50) begin
			n = ($urandom_range(4) == 0) ? $urandom_range(9, 22) : $urandom_range(1, 5);
			for (int i = 0; i < n; i++)
				send_char(8'("0" + $urandom_range(9)), 1'b0);
			case ($urandom_range(4))
				0: send_char($urandom_range(1) ? CH_LU : CH_UU, 1'b0);
				1: send_char($urandom_range(1) ? CH_LL : CH_UL, 1'b0);
				2: begin
					send_char($urandom_range(1) ? CH_LU : CH_UU, 1'b0);
					send_char($urandom_range(1) ? CH_LL : CH_UL, 1'b0);
				end
				default: ;
			endcase
		end else if (pick < 75) begin
			send_char(CH_QUOTE, 1'b0);
			n = ($urandom_range(14) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 6);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(9))
					0: begin
						send_char(CH_BSL, 1'b0);
						case ($urandom_range(7))
							0: send_char(CH_QUOTE, 1'b0);
							1: send_char(CH_BSL, 1'b0);
							2: send_char(CH_T, 1'b0);
							3: send_char(CH_N, 1'b0);
							4: send_char(CH_R, 1'b0);
							5: send_char(CH_B, 1'b0);
							6: send_char(CH_F, 1'b0);
							default: send_char("x", 1'b0);
						endcase
					end
					1: send_char(8'($urandom_range(128, 255)), 1'b0);
					default: send_char(($urandom_range(32, 126) == CH_QUOTE) ? 8'("q")
						: 8'("a" + i % 26), 1'b0);
				endcase
			end
			if ($urandom_range(9) == 0)
				send_char(8'($urandom_range(255)), 1'b1);
			else
				send_char(CH_QUOTE, 1'b0);
		end else if (pick < 85) begin
			case ($urandom_range(3))
				0: send_char(CH_SPACE, 1'b0);
				1: send_char(CH_TAB, 1'b0);
				2: send_char(CH_LF, 1'b0);
				default: send_char(CH_CR, 1'b0);
			endcase
		end else if (pick < 96) begin
			send_char(8'($urandom_range(255)), 1'b0);
		end else begin
			send_char(8'($urandom_range(255)), 1'b1);
		end
	endtask

	task automatic test_random(input int count);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < count)
			send_random_token();
		send_char(8'($urandom_range(255)), 1'b1);
	endtask

	// The receiver holds off for a long stretch while long words keep coming,
	// so results wait and the block stalls its input.
	task automatic test_backpressure();
		hold_req++;
		for (int w = 0; w < 2; w++) begin
			for (int i = 0; i < 40; i++)
				send_char(8'("a" + $urandom_range(25)), 1'b0);
			send_char(CH_LF, 1'b0);
		end
		send_char(8'h00, 1'b1);
	endtask

	initial begin
		keep_sp = 1'b0;
		clear_token();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_words_symbols();
		test_numbers();
		test_strings();
		test_random(30);

		// Spaces become symbols in this phase; no idling on either side at its start.
		write_keep_spaces(1'b1);
		gaps_on = 1'b0;
		send_text("a b 1 \" \" ");
		test_random(30);
		gaps_on = 1'b1;
		test_random(15);
		test_backpressure();

		write_keep_spaces(1'b0);
		test_random(15);

		@(posedge clk);
		char_valid <= 1'b0;
		wait (tokens_due.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("Sent %0d byte and end requests, checked %0d token results,", bytes_sent,
			tokens_seen);
		$display("with keep_spaces off and on, random idling and a long receiver hold-off.");
		if (errors == 0)
			$display("tb_source_text_lexer_unit passed");
		else
			$display("tb_source_text_lexer_unit failed");
		$finish;
	end

endmodule
